>>> src/aspc_pkg.sv
// Shared constants, types and character codes for the ASCII stepper position controller.
// Used by every module and by the channel interfaces' users; depends on nothing.
package aspc_pkg;

  // Default configuration of the controller
  localparam int MOTOR_COUNT_DEF    = 2;
  localparam int LINE_DEPTH_DEF     = 20;
  localparam int POSITION_SHIFT_DEF = 4;

  // Fixed widths
  localparam int NUM_LINES   = 2;   // motor line bits on the result item
  localparam int POS_W       = 29;  // signed position width
  localparam int ACC_W       = 24;  // holds up to seven decimal digits
  localparam int DIG_N       = 9;   // BCD digits for a 29-bit magnitude
  localparam int DIG_W       = 4;   // index width over the BCD digits
  localparam int BCD_W       = 4 * DIG_N;
  localparam int MIN_DIGITS  = 6;   // report pads to at least six digits
  localparam int CMD_MAX_LEN = 9;   // motor index, sign and seven digits
  localparam int MAX_RES     = 49;  // reply characters per transaction
  localparam int CNT_W       = 6;

  localparam logic signed [31:0] POS_MAX = 32'sd268435455;
  localparam logic signed [31:0] POS_MIN = -32'sd268435456;

  // Character codes
  localparam logic [7:0] CH_QUERY = 8'h3F;  // ?
  localparam logic [7:0] CH_HASH  = 8'h23;  // #
  localparam logic [7:0] CH_STOP  = 8'h53;  // S
  localparam logic [7:0] CH_ZERO_CMD = 8'h5A;  // Z
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG1  = 8'h31;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_OK    = 8'h24;  // $
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_C     = 8'h43;

  typedef logic signed [POS_W-1:0] pos_t;

  // Motor commands issued by the sequencer
  typedef enum logic [1:0] {
    MOP_STOP,
    MOP_ZERO,
    MOP_MOVE
  } mop_e;

  typedef struct packed {
    logic valid;
    mop_e op;
    logic idx;
    pos_t value;
  } mcmd_t;

endpackage

>>> src/aspc_if.sv
// Valid/ready channel interfaces for request and result transactions.
// Stand-alone; payload widths follow the fixed item fields.
interface aspc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source(output valid, req_type, rx_byte, input ready);
  modport sink(input valid, req_type, rx_byte, output ready);
endinterface

interface aspc_rsp_if;
  logic       valid;
  logic       ready;
  logic       reply_valid;
  logic [7:0] reply_char;
  logic       reply_last;
  logic [1:0] step_lines;
  logic [1:0] dir_lines;
  logic [1:0] enable_n_lines;
  logic       fan_on;

  modport source(output valid, reply_valid, reply_char, reply_last, step_lines,
                 dir_lines, enable_n_lines, fan_on, input ready);
  modport sink(input valid, reply_valid, reply_char, reply_last, step_lines,
               dir_lines, enable_n_lines, fan_on, output ready);
endinterface

>>> src/ascii_stepper_position_controller.sv
// Top level of the ASCII stepper position controller: line buffer, command sequencer,
// reply text generation and output register. Depends on aspc_pkg, aspc_if, aspc_bcd, aspc_motors.
//
// One request transaction is handled at a time; ready is high only while the sequencer
// is idle. A move parses one digit per cycle, and for a '?' report each of the
// 2 x MOTOR_COUNT values passes through the serial BCD converter, which takes one bit
// per cycle, before its reply characters are emitted. Results leave through a registered
// output stage, so a stalled sink only holds the sequencer when a new character is due.
module ascii_stepper_position_controller import aspc_pkg::*; #(
  parameter int MOTOR_COUNT    = MOTOR_COUNT_DEF,
  parameter int LINE_DEPTH     = LINE_DEPTH_DEF,
  parameter int POSITION_SHIFT = POSITION_SHIFT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aspc_req_if.sink    req_i,
  aspc_rsp_if.source  rsp_o
);

  localparam int LEN_W = $clog2(LINE_DEPTH + 1);
  localparam int IDX_W = $clog2(LINE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_NONE, ST_DECODE, ST_PARSE, ST_APPLY, ST_SHORT, ST_CONV, ST_WAIT,
    ST_PRE, ST_SIGN, ST_DIG, ST_SEP, ST_CR, ST_LF
  } state_e;

  state_e           state_q;
  logic [7:0]       line_q [LINE_DEPTH];
  logic [LEN_W-1:0] len_q, n_q, k_q;
  logic             fan_q, neg_q, m_q, started_q;
  logic [7:0]       c0_q;
  logic [ACC_W-1:0] acc_q;
  logic [1:0]       fld_q, p_q;
  logic [DIG_W-1:0] dig_q;
  logic [CNT_W-1:0] cnt_q;

  // Output register
  logic       ovalid_q, orv_q, olast_q, ofan_q;
  logic [7:0] ochar_q;
  logic [1:0] ostep_q, odir_q, oen_q;

  logic accept, tick, is_eol;
  logic [7:0] cb0, cb1, kb;
  logic c_motor, c_sign, midx, is_dig;
  logic [ACC_W-1:0] acc_next;
  logic signed [31:0] mv_s, mv_sh;
  pos_t mv_sat, sel_pos, rep_v;
  logic [POS_W-1:0] rep_mag;
  mcmd_t cmd;
  logic bcd_start, bcd_busy;
  logic [BCD_W-1:0] bcd;
  logic [3:0] dig_v;
  logic emit, evld, efin, elast, out_free, go, last_fld;
  logic [7:0] ech;
  pos_t tgt [NUM_LINES];
  pos_t cur [NUM_LINES];
  logic [NUM_LINES-1:0] step_l, dir_l, en_l;

  assign req_i.ready = state_q == ST_IDLE;
  assign accept      = req_i.valid && req_i.ready;
  assign tick        = accept && req_i.req_type;
  assign is_eol      = req_i.rx_byte == CH_CR || req_i.rx_byte == CH_LF;

  // Decode the buffered line
  assign cb0     = line_q[0];
  assign cb1     = line_q[1];
  assign c_motor = cb0 > CH_DIG0 && cb0 <= 8'(CH_DIG0 + MOTOR_COUNT);
  assign c_sign  = cb1 == CH_PLUS || cb1 == CH_MINUS;
  assign midx    = 1'(cb0 - CH_DIG1);

  // Accumulate one decimal digit per cycle
  assign kb       = line_q[k_q[IDX_W-1:0]];
  assign is_dig   = kb >= CH_DIG0 && kb <= CH_DIG9;
  assign acc_next = (acc_q << 3) + (acc_q << 1) + ACC_W'(kb[3:0]);

  // Sign, scale and saturate the move target
  assign mv_s   = neg_q ? -$signed({8'b0, acc_q}) : $signed({8'b0, acc_q});
  assign mv_sh  = mv_s <<< POSITION_SHIFT;
  assign mv_sat = (mv_sh > POS_MAX) ? POS_W'(POS_MAX) :
                  (mv_sh < POS_MIN) ? POS_W'(POS_MIN) : POS_W'(mv_sh);

  // Motor command: stop and zero from decode, move after parsing
  always_comb begin
    cmd.valid = (state_q == ST_DECODE && c_motor && n_q == LEN_W'(2) &&
                 (cb1 == CH_STOP || cb1 == CH_ZERO_CMD)) || state_q == ST_APPLY;
    cmd.op    = (state_q == ST_APPLY) ? MOP_MOVE : ((cb1 == CH_STOP) ? MOP_STOP : MOP_ZERO);
    cmd.idx   = (state_q == ST_APPLY) ? m_q : midx;
    cmd.value = mv_sat;
  end

  aspc_motors #(.MOTOR_COUNT(MOTOR_COUNT)) u_motors (
    .clk_i, .rst_ni, .tick_i(tick), .cmd_i(cmd), .target_o(tgt), .current_o(cur),
    .step_o(step_l), .dir_o(dir_l), .enable_n_o(en_l)
  );

  // Report value: scaled position and its magnitude
  assign sel_pos   = fld_q[0] ? cur[fld_q[1]] : tgt[fld_q[1]];
  assign rep_v     = sel_pos >>> POSITION_SHIFT;
  assign rep_mag   = rep_v[POS_W-1] ? POS_W'(0) - rep_v : rep_v;
  assign bcd_start = state_q == ST_CONV;
  assign last_fld  = fld_q[1] == 1'(MOTOR_COUNT - 1) && fld_q[0];

  aspc_bcd u_bcd (
    .clk_i, .rst_ni, .start_i(bcd_start), .bin_i(rep_mag), .busy_o(bcd_busy), .bcd_o(bcd)
  );

  assign dig_v = bcd[dig_q*4 +: 4];

  // Character to emit in the current state
  always_comb begin
    emit = 1'b0;
    evld = 1'b1;
    efin = 1'b0;
    ech  = '0;
    unique case (state_q)
      ST_NONE: begin
        emit = 1'b1;
        evld = 1'b0;
        efin = 1'b1;
      end
      ST_SHORT: begin
        emit = 1'b1;
        ech  = c0_q;
      end
      ST_CR: begin
        emit = 1'b1;
        ech  = CH_CR;
      end
      ST_LF: begin
        emit = 1'b1;
        ech  = CH_LF;
        efin = 1'b1;
      end
      ST_PRE: begin
        emit = 1'b1;
        if (p_q == 2'd0)      ech = fld_q[0] ? CH_C : CH_T;
        else if (p_q == 2'd1) ech = CH_DIG1 + 8'(fld_q[1]);
        else                  ech = CH_EQ;
      end
      ST_SIGN: begin
        emit = 1'b1;
        ech  = neg_q ? CH_MINUS : CH_PLUS;
      end
      ST_DIG: begin
        emit = started_q || dig_v != 4'd0 || dig_q < DIG_W'(MIN_DIGITS);
        ech  = CH_DIG0 + 8'(dig_v);
      end
      ST_SEP: begin
        emit = 1'b1;
        ech  = CH_COMMA;
      end
      default: ;
    endcase
  end

  assign elast    = efin || cnt_q == CNT_W'(MAX_RES - 1);
  assign out_free = !ovalid_q || rsp_o.ready;
  assign go       = emit && out_free;

  // Line buffer: store bytes up to the depth
  always_ff @(posedge clk_i) begin
    if (accept && !req_i.req_type && !(len_q != '0 && is_eol) &&
        len_q < LEN_W'(LINE_DEPTH)) begin
      line_q[len_q[IDX_W-1:0]] <= req_i.rx_byte;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      n_q       <= '0;
      k_q       <= '0;
      fan_q     <= 1'b0;
      neg_q     <= 1'b0;
      m_q       <= 1'b0;
      started_q <= 1'b0;
      c0_q      <= '0;
      acc_q     <= '0;
      fld_q     <= '0;
      p_q       <= '0;
      dig_q     <= '0;
      cnt_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            if (req_i.req_type) begin
              state_q <= ST_NONE;
            end else if (len_q != '0 && is_eol) begin
              n_q     <= len_q;
              state_q <= ST_DECODE;
            end else begin
              if (len_q < LEN_W'(LINE_DEPTH)) len_q <= len_q + LEN_W'(1);
              state_q <= ST_NONE;
            end
          end
        end
        ST_DECODE: begin
          len_q <= '0;
          priority if (n_q == LEN_W'(1) && cb0 == CH_QUERY) begin
            fld_q   <= '0;
            state_q <= ST_CONV;
          end else if (n_q == LEN_W'(1) && cb0 == CH_HASH) begin
            c0_q    <= fan_q ? CH_DIG1 : CH_DIG0;
            state_q <= ST_SHORT;
          end else if (n_q == LEN_W'(2) && cb0 == CH_HASH &&
                       (cb1 == CH_DIG0 || cb1 == CH_DIG1)) begin
            fan_q   <= cb1[0];
            c0_q    <= CH_OK;
            state_q <= ST_SHORT;
          end else if (c_motor) begin
            m_q <= midx;
            priority if (n_q == LEN_W'(2) && (cb1 == CH_STOP || cb1 == CH_ZERO_CMD)) begin
              c0_q    <= CH_OK;
              state_q <= ST_SHORT;
            end else if (n_q > LEN_W'(2) && c_sign) begin
              if (n_q > LEN_W'(CMD_MAX_LEN)) begin
                c0_q    <= CH_QUERY;
                state_q <= ST_SHORT;
              end else begin
                k_q     <= LEN_W'(2);
                acc_q   <= '0;
                neg_q   <= cb1 == CH_MINUS;
                state_q <= ST_PARSE;
              end
            end else begin
              state_q <= ST_NONE;
            end
          end else begin
            c0_q    <= CH_QUERY;
            state_q <= ST_SHORT;
          end
        end
        ST_PARSE: begin
          if (!is_dig) begin
            c0_q    <= CH_QUERY;
            state_q <= ST_SHORT;
          end else begin
            acc_q <= acc_next;
            k_q   <= k_q + LEN_W'(1);
            if (k_q + LEN_W'(1) == n_q) state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          c0_q    <= CH_OK;
          state_q <= ST_SHORT;
        end
        ST_CONV: begin
          neg_q     <= rep_v[POS_W-1];
          dig_q     <= DIG_W'(DIG_N - 1);
          started_q <= 1'b0;
          p_q       <= '0;
          state_q   <= ST_WAIT;
        end
        ST_WAIT: begin
          if (!bcd_busy) state_q <= ST_PRE;
        end
        ST_PRE: begin
          if (go) begin
            p_q <= p_q + 2'd1;
            if (p_q == 2'd2) state_q <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          if (go) state_q <= ST_DIG;
        end
        ST_DIG: begin
          if (!emit || out_free) begin
            if (emit) started_q <= 1'b1;
            if (dig_q == '0) state_q <= last_fld ? ST_CR : ST_SEP;
            else             dig_q <= dig_q - DIG_W'(1);
          end
        end
        ST_SEP: begin
          if (go) begin
            fld_q   <= fld_q + 2'd1;
            state_q <= ST_CONV;
          end
        end
        ST_SHORT: begin
          if (go) state_q <= ST_CR;
        end
        ST_CR: begin
          if (go) state_q <= ST_LF;
        end
        ST_LF, ST_NONE: begin
          if (go) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      // Count reply characters; the last one ends the transaction
      if (go) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (elast) state_q <= ST_IDLE;
      end
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (go) begin
      ovalid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  // Output register payload: reply character and line levels
  always_ff @(posedge clk_i) begin
    if (go) begin
      orv_q   <= evld;
      ochar_q <= ech;
      olast_q <= elast;
      ostep_q <= step_l;
      odir_q  <= dir_l;
      oen_q   <= en_l;
      ofan_q  <= fan_q;
    end
  end

  assign rsp_o.valid          = ovalid_q;
  assign rsp_o.reply_valid    = orv_q;
  assign rsp_o.reply_char     = ochar_q;
  assign rsp_o.reply_last     = olast_q;
  assign rsp_o.step_lines     = ostep_q;
  assign rsp_o.dir_lines      = odir_q;
  assign rsp_o.enable_n_lines = oen_q;
  assign rsp_o.fan_on         = ofan_q;

  // Checks
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(LINE_DEPTH)) else $error("line length beyond buffer depth");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RES)) else $error("reply longer than the result limit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready) else $error("request taken while a transaction is open");

  a_bcd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !bcd_busy) else $error("converter busy while idle");

endmodule

>>> src/aspc_bcd.sv
// Serial binary to BCD converter (shift and add-3), one bit per clock.
// Depends on aspc_pkg for the position and BCD widths.
module aspc_bcd import aspc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [POS_W-1:0]   bin_i,
  output logic               busy_o,
  output logic [BCD_W-1:0]   bcd_o
);

  localparam int CB_W = $clog2(POS_W + 1);

  logic [POS_W-1:0] bin_q;
  logic [BCD_W-1:0] bcd_q, adj;
  logic [CB_W-1:0]  cnt_q;
  logic             busy_q;

  // Correct every digit that would overflow on the next shift
  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  // Control: count the bits still to shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CB_W'(POS_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CB_W'(1);
      if (cnt_q == CB_W'(1)) busy_q <= 1'b0;
    end
  end

  // Datapath: shift the next binary bit into the digits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= bin_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[POS_W-2:0], 1'b0};
      bcd_q <= {adj[BCD_W-2:0], bin_q[POS_W-1]};
    end
  end

  assign busy_o = busy_q;
  assign bcd_o  = bcd_q;

endmodule

>>> src/aspc_motors.sv
// Per-motor target/current positions and step, dir and enable generation.
// Depends on aspc_pkg for position types and the motor command struct.
module aspc_motors import aspc_pkg::*; #(
  parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  mcmd_t                cmd_i,
  output pos_t                 target_o  [NUM_LINES],
  output pos_t                 current_o [NUM_LINES],
  output logic [NUM_LINES-1:0] step_o,
  output logic [NUM_LINES-1:0] dir_o,
  output logic [NUM_LINES-1:0] enable_n_o
);

  pos_t                 tgt_q [NUM_LINES];
  pos_t                 cur_q [NUM_LINES];
  logic [NUM_LINES-1:0] act_q, step_q, dir_q, ne, lt;

  // Compare each motor's position against its target
  always_comb begin
    for (int m = 0; m < NUM_LINES; m++) begin
      ne[m] = cur_q[m] != tgt_q[m];
      lt[m] = cur_q[m] < tgt_q[m];
    end
  end

  // Advance motors on a tick, apply commands otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NUM_LINES; m++) begin
        tgt_q[m] <= '0;
        cur_q[m] <= '0;
      end
      act_q  <= '0;
      step_q <= '0;
      dir_q  <= '0;
    end else begin
      for (int m = 0; m < NUM_LINES; m++) begin
        if (m < MOTOR_COUNT) begin
          if (tick_i) begin
            if (!act_q[m] && ne[m]) begin
              act_q[m]  <= 1'b1;
              step_q[m] <= 1'b1;
            end else if (ne[m]) begin
              dir_q[m]  <= lt[m];
              if (!step_q[m]) cur_q[m] <= lt[m] ? cur_q[m] + pos_t'(1) : cur_q[m] - pos_t'(1);
              step_q[m] <= !step_q[m];
            end else if (act_q[m]) begin
              act_q[m] <= 1'b0;
            end
          end else if (cmd_i.valid && cmd_i.idx == 1'(m)) begin
            unique case (cmd_i.op)
              MOP_STOP: tgt_q[m] <= cur_q[m];
              MOP_ZERO: begin
                tgt_q[m] <= '0;
                cur_q[m] <= '0;
              end
              MOP_MOVE: tgt_q[m] <= cmd_i.value;
              default: ;
            endcase
          end
        end
      end
    end
  end

  assign target_o   = tgt_q;
  assign current_o  = cur_q;
  assign step_o     = step_q;
  assign dir_o      = dir_q;
  assign enable_n_o = ~act_q;

endmodule
